>>> rtl/rlpm_pkg.sv
package rlpm_pkg;

  // Fixed field widths
  localparam int ADDR_W     = 64;
  localparam int PLEN_W     = 8;
  localparam int COUNT_W    = 5;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 64;

  // Longest prefix that can still match a lookup
  localparam logic [PLEN_W-1:0] MAX_PREFIX  = 8'd128;
  localparam logic [PLEN_W-1:0] HALF_PREFIX = 8'd64;

  // Address bit that selects the 64-bit register (registers at 0 and 8)
  localparam int REG_SEL_BIT = 3;
  localparam logic REG_DGW_HI = 1'b0;
  localparam logic REG_DGW_LO = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_NOT_FOUND   = 2'd2,
    ST_UNREACHABLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // One route as stored in the table (also used as the request key)
  typedef struct packed {
    logic [ADDR_W-1:0] network_hi;
    logic [ADDR_W-1:0] network_lo;
    logic [PLEN_W-1:0] prefix;
    logic [ADDR_W-1:0] gateway_hi;
    logic [ADDR_W-1:0] gateway_lo;
  } route_t;

  // Compare results for one table entry
  typedef struct packed {
    logic exact;
    logic prefix_hit;
  } match_t;

  // Mask with the top n bits of a 64-bit word set, n clamped to 0..64
  function automatic logic [ADDR_W-1:0] top_mask(input logic [PLEN_W-1:0] n);
    logic [ADDR_W-1:0] m;
    if (n == '0) begin
      m = '0;
    end else if (n >= HALF_PREFIX) begin
      m = '1;
    end else begin
      m = {ADDR_W{1'b1}} << (HALF_PREFIX - n);
    end
    return m;
  endfunction

endpackage

>>> rtl/rlpm_entry_mem.sv
module rlpm_entry_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_idx,
  output rlpm_pkg::route_t     rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  rlpm_pkg::route_t     wr_data
);
  import rlpm_pkg::*;

  route_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

>>> rtl/rlpm_match.sv
module rlpm_match (
  input  rlpm_pkg::route_t entry,
  input  logic             entry_valid,
  input  rlpm_pkg::route_t key,
  output rlpm_pkg::match_t hit
);
  import rlpm_pkg::*;

  logic [ADDR_W-1:0] mask_hi;
  logic [ADDR_W-1:0] mask_lo;
  logic              net_eq;
  logic              pfx_eq;

  // Build the prefix masks for both halves
  always_comb begin
    mask_hi = top_mask(entry.prefix);
    mask_lo = top_mask((entry.prefix > HALF_PREFIX) ? (entry.prefix - HALF_PREFIX)
                                                     : '0);
  end

  // Exact match for add and remove, masked match for lookup
  always_comb begin
    net_eq = (entry.network_hi == key.network_hi) && (entry.network_lo == key.network_lo);
    pfx_eq = ((key.network_hi ^ entry.network_hi) & mask_hi) == '0 &&
             ((key.network_lo ^ entry.network_lo) & mask_lo) == '0;
    hit.exact      = entry_valid && net_eq && (entry.prefix == key.prefix);
    hit.prefix_hit = entry_valid && (entry.prefix <= MAX_PREFIX) && pfx_eq;
  end

endmodule

>>> rtl/ipv6_longest_prefix_route_table.sv
// IPv6 longest-prefix routing table.
// Input channel (in_valid/in_stall) carries one operation word: opcode, a
// 128-bit address as address_hi/address_lo, prefix_length and a gateway.
// Add updates an exact route or fills the lowest free slot, remove clears
// the exact route, lookup returns the next hop of the longest match or the default gateway.
// Output channel (out_valid/out_stall) returns one word per operation:
// status, next hop and the route count after the operation.
// Every operation walks all ROUTE_ENTRIES slots of the route memory, one
// read per cycle through its single read port, then passes a drain and a
// finish step; a new operation is taken only once the last one is done.
// The next word is taken while a result still waits on the output; a
// finished operation holds its table update until the output register is
// free, so a stalled receiver stalls the table but loses nothing.
// Reset clears all slot valid bits, the route count, the default gateway
// and the output valid flag; route memory contents need no clearing.
// The default gateway sits at APB byte addresses 0 (upper) and 8 (lower).
module ipv6_longest_prefix_route_table #(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlpm_pkg::PADDR_W-1:0]  paddr,
  input  logic [rlpm_pkg::PDATA_W-1:0]  pwdata,
  output logic [rlpm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // Operation input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [rlpm_pkg::ADDR_W-1:0]   address_hi,
  input  logic [rlpm_pkg::ADDR_W-1:0]   address_lo,
  input  logic [rlpm_pkg::PLEN_W-1:0]   prefix_length,
  input  logic [rlpm_pkg::ADDR_W-1:0]   gateway_hi,
  input  logic [rlpm_pkg::ADDR_W-1:0]   gateway_lo,
  // Result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [rlpm_pkg::ADDR_W-1:0]   next_hop_hi,
  output logic [rlpm_pkg::ADDR_W-1:0]   next_hop_lo,
  output logic [rlpm_pkg::COUNT_W-1:0]  route_count
);
  import rlpm_pkg::*;

  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

  state_t state;
  state_t state_next;

  // Configuration
  logic [ADDR_W-1:0] dgw_hi;
  logic [ADDR_W-1:0] dgw_lo;
  logic              cfg_wr;

  // Captured request
  op_t    req_op;
  route_t req;

  // Table state
  logic [ROUTE_ENTRIES-1:0] valid_q;
  logic [COUNT_W-1:0]       cnt;

  // Scan pipeline
  logic [IDX_W-1:0] rd_idx;
  logic             rd_en;
  logic             ev_vld;
  logic [IDX_W-1:0] ev_idx;
  route_t           ev_entry;
  match_t           ev_hit;
  logic             accept;
  logic             commit;

  // Scan trackers
  logic               have_hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               have_free;
  logic [IDX_W-1:0]   free_idx;
  logic               have_best;
  logic [PLEN_W-1:0]  best_plen;
  logic [ADDR_W-1:0]  best_gw_hi;
  logic [ADDR_W-1:0]  best_gw_lo;

  // Commit decisions
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic               set_valid;
  logic               clr_valid;
  logic [COUNT_W-1:0] cnt_next;
  status_t            res_status;
  logic [ADDR_W-1:0]  res_hi;
  logic [ADDR_W-1:0]  res_lo;

  // APB: always ready, 64-bit registers decoded by one address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = (paddr[REG_SEL_BIT] == REG_DGW_LO) ? dgw_lo : dgw_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dgw_hi <= '0;
      dgw_lo <= '0;
    end else if (cfg_wr) begin
      if (paddr[REG_SEL_BIT] == REG_DGW_LO) begin
        dgw_lo <= pwdata;
      end else begin
        dgw_hi <= pwdata;
      end
    end
  end

  // Route memory and per-entry compare
  rlpm_entry_mem #(
    .DEPTH (ROUTE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (ev_entry),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (req)
  );

  rlpm_match u_match (
    .entry       (ev_entry),
    .entry_valid (valid_q[ev_idx]),
    .key         (req),
    .hit         (ev_hit)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencing
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    accept     = 1'b0;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (rd_idx == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Capture request, advance read index, track scan results
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op         <= op_t'(opcode);
      req.network_hi <= address_hi;
      req.network_lo <= address_lo;
      req.prefix     <= prefix_length;
      req.gateway_hi <= gateway_hi;
      req.gateway_lo <= gateway_lo;
    end
    ev_idx <= rd_idx;
    if (accept) begin
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_vld    <= 1'b0;
      have_hit  <= 1'b0;
      have_free <= 1'b0;
      have_best <= 1'b0;
    end else begin
      ev_vld <= rd_en;
      if (accept) begin
        have_hit  <= 1'b0;
        have_free <= 1'b0;
        have_best <= 1'b0;
      end else if (ev_vld) begin
        if (ev_hit.exact && !have_hit) begin
          have_hit <= 1'b1;
          hit_idx  <= ev_idx;
        end
        if (!valid_q[ev_idx] && !have_free) begin
          have_free <= 1'b1;
          free_idx  <= ev_idx;
        end
        if (ev_hit.prefix_hit && (!have_best || ev_entry.prefix > best_plen)) begin
          have_best  <= 1'b1;
          best_plen  <= ev_entry.prefix;
          best_gw_hi <= ev_entry.gateway_hi;
          best_gw_lo <= ev_entry.gateway_lo;
        end
      end
    end
  end

  // Decide table update and result from the finished scan
  always_comb begin
    wr_en      = 1'b0;
    wr_idx     = have_hit ? hit_idx : free_idx;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    cnt_next   = cnt;
    res_status = ST_OK;
    res_hi     = '0;
    res_lo     = '0;
    case (req_op)
      OP_ADD: begin
        if (have_hit) begin
          wr_en = commit;
        end else if (have_free) begin
          wr_en     = commit;
          set_valid = commit;
          cnt_next  = cnt + COUNT_W'(1);
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (have_hit) begin
          clr_valid = commit;
          cnt_next  = cnt - COUNT_W'(1);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        if (have_best) begin
          if (best_gw_hi == '0 && best_gw_lo == '0) begin
            res_hi = req.network_hi;
            res_lo = req.network_lo;
          end else begin
            res_hi = best_gw_hi;
            res_lo = best_gw_lo;
          end
        end else if (dgw_hi != '0 || dgw_lo != '0) begin
          res_hi = dgw_hi;
          res_lo = dgw_lo;
        end else begin
          res_status = ST_UNREACHABLE;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Valid bits and route count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      cnt     <= '0;
    end else begin
      if (set_valid) begin
        valid_q[free_idx] <= 1'b1;
      end
      if (clr_valid) begin
        valid_q[hit_idx] <= 1'b0;
      end
      if (commit) begin
        cnt <= cnt_next;
      end
    end
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status      <= res_status;
      next_hop_hi <= res_hi;
      next_hop_lo <= res_lo;
      route_count <= cnt_next;
    end
  end

  // Route count always tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    cnt == COUNT_W'($countones(valid_q)))
    else $error("route count out of step with valid bits");

  // A result only appears from the finishing step
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside finish step");

  // An accepted word starts a scan at slot zero
  a_scan_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_SCAN && rd_idx == '0))
    else $error("scan did not start at slot zero");

endmodule
